>>> rtl/iadv_pkg.sv
// Package of types, widths, constants and helpers for the IMU delta angle and velocity integrator.
package iadv_pkg;

  localparam int unsigned RateW  = 24;
  localparam int unsigned DtW    = 16;
  localparam int unsigned SumW   = 48;
  localparam int unsigned TimeW  = 32;
  localparam int unsigned CountW = 16;

  localparam int unsigned MulW     = 42;
  localparam int unsigned DaW      = 37;
  localparam int unsigned DvW      = 38;
  localparam int unsigned DivW     = 41;
  localparam int unsigned DivShift = 37;
  localparam int unsigned BaseW    = 49;
  localparam int unsigned XW       = 88;
  localparam int unsigned SatW     = 57;
  localparam int unsigned CtrW     = 6;
  localparam int unsigned DaShift  = 5;
  localparam int unsigned DvShift  = 4;
  localparam int unsigned ConShift = 33;

  localparam logic [DtW-1:0] MaxStepRst = 16'd52429;

  typedef enum logic [1:0] {
    ACT_PUSH  = 2'd0,
    ACT_TAKE  = 2'd1,
    ACT_CLEAR = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CALC,
    ST_PREP,
    ST_CROSS_A,
    ST_CROSS_B,
    ST_UPDATE
  } state_e;

  typedef struct packed {
    logic [1:0]              action;
    logic signed [RateW-1:0] gyro_x;
    logic signed [RateW-1:0] gyro_y;
    logic signed [RateW-1:0] gyro_z;
    logic signed [RateW-1:0] accel_x;
    logic signed [RateW-1:0] accel_y;
    logic signed [RateW-1:0] accel_z;
    logic [DtW-1:0]          step_time;
  } in_req_t;

  typedef struct packed {
    logic                   valid_res;
    logic signed [SumW-1:0] angle_delta_x;
    logic signed [SumW-1:0] angle_delta_y;
    logic signed [SumW-1:0] angle_delta_z;
    logic signed [SumW-1:0] velocity_delta_x;
    logic signed [SumW-1:0] velocity_delta_y;
    logic signed [SumW-1:0] velocity_delta_z;
    logic [TimeW-1:0]       elapsed_time;
    logic [CountW-1:0]      sample_total;
  } out_res_t;

  localparam logic signed [SatW-1:0] SatMax = {{(SatW-SumW+1){1'b0}}, {(SumW-1){1'b1}}};
  localparam logic signed [SatW-1:0] SatMin = ~SatMax;

  function automatic logic signed [SumW-1:0] sat48(input logic signed [SatW-1:0] v);
    logic signed [SumW-1:0] r;
    if (v > SatMax) begin
      r = SatMax[SumW-1:0];
    end else if (v < SatMin) begin
      r = SatMin[SumW-1:0];
    end else begin
      r = v[SumW-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/imu_delta_angle_velocity_integrator_top.sv
// Top level of the IMU delta angle and velocity integrator with coning correction.
// A take, a clear, a priming push and a rejected push each complete in the cycle they are
// accepted. After acceptance, an integrating push occupies the block for bit-serial division
// by six (the trapezoidal products run in the same pass, one bit of step time per cycle), a
// preparation step, two bit-serial passes of the coning cross product and an update step.
// A result waits in an output register, and further pushes and clears are taken while it
// waits; a take waits until it has been delivered.
module imu_delta_angle_velocity_integrator_top (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  iadv_pkg::in_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output iadv_pkg::out_res_t out_data_o
);

  localparam logic signed [iadv_pkg::MulW-1:0] DaRnd = 16;
  localparam logic signed [iadv_pkg::MulW-1:0] DvRnd = 8;
  localparam logic signed [iadv_pkg::XW-1:0] ConRnd =
    {{(iadv_pkg::XW-33){1'b0}}, 1'b1, {32{1'b0}}};
  localparam logic [iadv_pkg::DivW-1:0] DivBias =
    {{(iadv_pkg::DivW-iadv_pkg::DivShift-3){1'b0}}, 3'b110, {iadv_pkg::DivShift{1'b0}}};
  localparam logic [iadv_pkg::DivW:0] QOff =
    {{(iadv_pkg::DivW-iadv_pkg::DivShift){1'b0}}, 1'b1, {iadv_pkg::DivShift{1'b0}}};

  iadv_pkg::state_e state_q, state_d;
  logic [iadv_pkg::CtrW-1:0] cnt_q, cnt_d;

  logic [iadv_pkg::DtW-1:0]    max_step_q;
  logic                        primed_q;
  logic signed [iadv_pkg::RateW-1:0] prev_rate_q [3];
  logic signed [iadv_pkg::RateW-1:0] prev_force_q [3];
  logic signed [iadv_pkg::SumW-1:0]  ang_q [3];
  logic signed [iadv_pkg::SumW-1:0]  vel_q [3];
  logic signed [iadv_pkg::DaW-1:0]   pas_q [3];
  logic [iadv_pkg::TimeW-1:0]  time_q;
  logic [iadv_pkg::CountW-1:0] count_q;
  logic                        out_valid_q;
  iadv_pkg::out_res_t          out_data_q;

  logic signed [iadv_pkg::MulW-1:0] mr_mc_q [3];
  logic signed [iadv_pkg::MulW-1:0] mr_acc_q [3];
  logic signed [iadv_pkg::MulW-1:0] mf_mc_q [3];
  logic signed [iadv_pkg::MulW-1:0] mf_acc_q [3];
  logic [iadv_pkg::DtW-1:0]         dt_sh_q;
  logic [iadv_pkg::DivW-1:0]        num_q [3];
  logic [2:0]                       rem_q [3];
  logic signed [iadv_pkg::DaW-1:0]   da_q [3];
  logic signed [iadv_pkg::BaseW-1:0] base_q [3];
  logic signed [iadv_pkg::XW-1:0]    xm_q [3];
  logic signed [iadv_pkg::DaW-1:0]   xb_q [3];
  logic signed [iadv_pkg::XW-1:0]    xacc_q [3];

  logic signed [iadv_pkg::RateW-1:0] g_w [3];
  logic signed [iadv_pkg::RateW-1:0] a_w [3];
  logic signed [iadv_pkg::RateW:0]   sr_w [3];
  logic signed [iadv_pkg::RateW:0]   sf_w [3];
  logic signed [iadv_pkg::MulW-1:0]  dash_w [3];
  logic signed [iadv_pkg::MulW-1:0]  dvsh_w [3];
  logic signed [iadv_pkg::DaW-1:0]   da_w [3];
  logic signed [iadv_pkg::DvW-1:0]   dv_w [3];
  logic signed [iadv_pkg::DivW:0]    q_w [3];
  logic signed [iadv_pkg::BaseW-1:0] base_w [3];
  logic signed [iadv_pkg::XW-1:0]    csh_w [3];
  logic signed [iadv_pkg::SatW-1:0]  asum_w [3];
  logic signed [iadv_pkg::SatW-1:0]  vsum_w [3];
  logic [3:0]                        r4_w [3];
  logic                              qb_w [3];

  logic in_acc, dt_ok, x_neg, x_last;
  logic [iadv_pkg::TimeW:0] tsum_w;

  assign in_acc = in_valid_i && !in_stall_o;
  assign dt_ok  = (in_data_i.step_time != '0) && (in_data_i.step_time <= max_step_q);
  assign tsum_w = {1'b0, time_q} + (iadv_pkg::TimeW+1)'(in_data_i.step_time);
  assign x_last = (cnt_q == iadv_pkg::CtrW'(iadv_pkg::DaW-1));
  assign x_neg  = x_last ^ (state_q == iadv_pkg::ST_CROSS_B);

  assign g_w[0] = in_data_i.gyro_x;
  assign g_w[1] = in_data_i.gyro_y;
  assign g_w[2] = in_data_i.gyro_z;
  assign a_w[0] = in_data_i.accel_x;
  assign a_w[1] = in_data_i.accel_y;
  assign a_w[2] = in_data_i.accel_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sr_w[i]   = (iadv_pkg::RateW+1)'(prev_rate_q[i]) + (iadv_pkg::RateW+1)'(g_w[i]);
      sf_w[i]   = (iadv_pkg::RateW+1)'(prev_force_q[i]) + (iadv_pkg::RateW+1)'(a_w[i]);
      dash_w[i] = (mr_acc_q[i] + DaRnd) >>> iadv_pkg::DaShift;
      dvsh_w[i] = (mf_acc_q[i] + DvRnd) >>> iadv_pkg::DvShift;
      da_w[i]   = dash_w[i][iadv_pkg::DaW-1:0];
      dv_w[i]   = dvsh_w[i][iadv_pkg::DvW-1:0];
      q_w[i]    = $signed({1'b0, num_q[i]}) - $signed(QOff);
      base_w[i] = iadv_pkg::BaseW'(ang_q[i]) + iadv_pkg::BaseW'(q_w[i]);
      csh_w[i]  = (xacc_q[i] + ConRnd) >>> iadv_pkg::ConShift;
      asum_w[i] = iadv_pkg::SatW'(ang_q[i]) + iadv_pkg::SatW'(da_q[i])
                + $signed(csh_w[i][iadv_pkg::SatW-1:0]);
      vsum_w[i] = iadv_pkg::SatW'(vel_q[i]) + iadv_pkg::SatW'(dv_w[i]);
      r4_w[i]   = {rem_q[i], num_q[i][iadv_pkg::DivW-1]};
      qb_w[i]   = (r4_w[i] >= 4'd6);
    end
  end

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q + 1'b1;
    case (state_q)
      iadv_pkg::ST_IDLE: begin
        cnt_d = '0;
        if (in_acc && in_data_i.action == iadv_pkg::ACT_PUSH && dt_ok && primed_q) begin
          state_d = iadv_pkg::ST_CALC;
        end
      end
      iadv_pkg::ST_CALC: begin
        if (cnt_q == iadv_pkg::CtrW'(iadv_pkg::DivW-1)) begin
          state_d = iadv_pkg::ST_PREP;
          cnt_d   = '0;
        end
      end
      iadv_pkg::ST_PREP: begin
        state_d = iadv_pkg::ST_CROSS_A;
        cnt_d   = '0;
      end
      iadv_pkg::ST_CROSS_A: begin
        if (x_last) begin
          state_d = iadv_pkg::ST_CROSS_B;
          cnt_d   = '0;
        end
      end
      iadv_pkg::ST_CROSS_B: begin
        if (x_last) begin
          state_d = iadv_pkg::ST_UPDATE;
          cnt_d   = '0;
        end
      end
      iadv_pkg::ST_UPDATE: begin
        state_d = iadv_pkg::ST_IDLE;
        cnt_d   = '0;
      end
      default: begin
        state_d = iadv_pkg::ST_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_comb begin
    in_stall_o  = (state_q != iadv_pkg::ST_IDLE)
               || (out_valid_q && in_data_i.action == iadv_pkg::ACT_TAKE);
    out_valid_o = out_valid_q;
    out_data_o  = out_data_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= iadv_pkg::ST_IDLE;
      cnt_q       <= '0;
      max_step_q  <= iadv_pkg::MaxStepRst;
      primed_q    <= 1'b0;
      time_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
      out_data_q  <= '0;
      for (int i = 0; i < 3; i++) begin
        prev_rate_q[i]  <= '0;
        prev_force_q[i] <= '0;
        ang_q[i]        <= '0;
        vel_q[i]        <= '0;
        pas_q[i]        <= '0;
      end
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      if (cfg_we_i) begin
        max_step_q <= cfg_wdata_i;
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (in_acc) begin
        case (in_data_i.action)
          iadv_pkg::ACT_PUSH: begin
            if (dt_ok) begin
              primed_q <= 1'b1;
              for (int i = 0; i < 3; i++) begin
                prev_rate_q[i]  <= g_w[i];
                prev_force_q[i] <= a_w[i];
              end
              if (primed_q) begin
                time_q <= tsum_w[iadv_pkg::TimeW] ? '1 : tsum_w[iadv_pkg::TimeW-1:0];
                if (count_q != '1) begin
                  count_q <= count_q + 1'b1;
                end
              end
            end
          end
          iadv_pkg::ACT_TAKE: begin
            out_valid_q <= 1'b1;
            if (count_q == '0) begin
              out_data_q <= '0;
            end else begin
              out_data_q.valid_res        <= 1'b1;
              out_data_q.angle_delta_x    <= ang_q[0];
              out_data_q.angle_delta_y    <= ang_q[1];
              out_data_q.angle_delta_z    <= ang_q[2];
              out_data_q.velocity_delta_x <= vel_q[0];
              out_data_q.velocity_delta_y <= vel_q[1];
              out_data_q.velocity_delta_z <= vel_q[2];
              out_data_q.elapsed_time     <= time_q;
              out_data_q.sample_total     <= count_q;
              time_q  <= '0;
              count_q <= '0;
              for (int i = 0; i < 3; i++) begin
                ang_q[i] <= '0;
                vel_q[i] <= '0;
              end
            end
          end
          iadv_pkg::ACT_CLEAR: begin
            time_q  <= '0;
            count_q <= '0;
            for (int i = 0; i < 3; i++) begin
              ang_q[i] <= '0;
              vel_q[i] <= '0;
              pas_q[i] <= '0;
            end
          end
          default: begin
          end
        endcase
      end
      if (state_q == iadv_pkg::ST_PREP) begin
        for (int i = 0; i < 3; i++) begin
          vel_q[i] <= iadv_pkg::sat48(vsum_w[i]);
        end
      end
      if (state_q == iadv_pkg::ST_UPDATE) begin
        for (int i = 0; i < 3; i++) begin
          ang_q[i] <= iadv_pkg::sat48(asum_w[i]);
          pas_q[i] <= da_q[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      iadv_pkg::ST_IDLE: begin
        dt_sh_q <= in_data_i.step_time;
        for (int i = 0; i < 3; i++) begin
          mr_mc_q[i]  <= iadv_pkg::MulW'(sr_w[i]);
          mf_mc_q[i]  <= iadv_pkg::MulW'(sf_w[i]);
          mr_acc_q[i] <= '0;
          mf_acc_q[i] <= '0;
          num_q[i]    <= iadv_pkg::DivW'(pas_q[i]) + iadv_pkg::DivW'(3) + DivBias;
          rem_q[i]    <= '0;
        end
      end
      iadv_pkg::ST_CALC: begin
        dt_sh_q <= dt_sh_q >> 1;
        for (int i = 0; i < 3; i++) begin
          if (dt_sh_q[0]) begin
            mr_acc_q[i] <= mr_acc_q[i] + mr_mc_q[i];
            mf_acc_q[i] <= mf_acc_q[i] + mf_mc_q[i];
          end
          mr_mc_q[i] <= mr_mc_q[i] <<< 1;
          mf_mc_q[i] <= mf_mc_q[i] <<< 1;
          rem_q[i]   <= qb_w[i] ? 3'(r4_w[i] - 4'd6) : r4_w[i][2:0];
          num_q[i]   <= {num_q[i][iadv_pkg::DivW-2:0], qb_w[i]};
        end
      end
      iadv_pkg::ST_PREP: begin
        for (int i = 0; i < 3; i++) begin
          da_q[i]   <= da_w[i];
          base_q[i] <= base_w[i];
          xm_q[i]   <= iadv_pkg::XW'(base_w[(i + 1) % 3]);
          xb_q[i]   <= da_w[(i + 2) % 3];
          xacc_q[i] <= '0;
        end
      end
      iadv_pkg::ST_CROSS_A, iadv_pkg::ST_CROSS_B: begin
        for (int i = 0; i < 3; i++) begin
          if (xb_q[i][0]) begin
            if (x_neg) begin
              xacc_q[i] <= xacc_q[i] - xm_q[i];
            end else begin
              xacc_q[i] <= xacc_q[i] + xm_q[i];
            end
          end
          if (x_last && state_q == iadv_pkg::ST_CROSS_A) begin
            xm_q[i] <= iadv_pkg::XW'(base_q[(i + 2) % 3]);
            xb_q[i] <= da_q[(i + 1) % 3];
          end else begin
            xm_q[i] <= xm_q[i] <<< 1;
            xb_q[i] <= xb_q[i] >>> 1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  a_calc_primed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == iadv_pkg::ST_CALC) |-> primed_q)
    else $error("integration running before priming");

  a_count_time : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (time_q == '0))
    else $error("elapsed time without integrated samples");

  a_busy_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != iadv_pkg::ST_IDLE) |-> in_stall_o)
    else $error("request taken while integrating");

  a_out_from_take : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(in_acc && in_data_i.action == iadv_pkg::ACT_TAKE))
    else $error("result raised without a take request");

endmodule
